@@ hdl/clint_pkg.sv @@
// Shared types and constants for the core-local interruptor.
// Operation codes, field widths and stream payload widths.
// No dependencies.
`timescale 1ns / 1ps

package clint_pkg;

   localparam int ADDR_W      = 16;
   localparam int DATA_W      = 32;
   localparam int TIME_W      = 64;
   localparam int VEC_W       = 4;
   localparam int OP_W        = 2;
   localparam int REQ_TDATA_W = 48;   // address, write_data
   localparam int RSP_TDATA_W = 40;   // read_data, timer_pending, software_pending

   // Offsets are decoded one bit wider so that base + 4 never wraps into the map
   localparam int DEC_W = ADDR_W + 1;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

endpackage

@@ hdl/core_local_interruptor_core.sv @@
// Core-local interruptor: 64-bit time counter, per-hart compare registers
// and software interrupt bits behind a 32-bit register map.
// Depends on clint_pkg.
`timescale 1ns / 1ps

// A result passes through the input register, the state update stage and the
// result register.
// Throughput: one item per cycle; the pipeline stalls only when the result
// register is full and not taken, and each stage refills as it empties.
// Reset (synchronous, active high) clears time to zero, sets every compare
// register to all ones, clears the software bits and empties the pipeline.
module core_local_interruptor_core #(
   parameter int NUM_HARTS       = 4,
   parameter int MSIP_OFFSET     = 0,
   parameter int MTIMECMP_OFFSET = 16384,
   parameter int MTIME_OFFSET    = 49144
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] address, [47:16] write_data
   input  logic [clint_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] operation
   input  logic [clint_pkg::OP_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] read_data, [35:32] timer_pending, [39:36] software_pending
   output logic [clint_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import clint_pkg::*;

   localparam int HART_W    = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;
   localparam int VEC_HARTS = (NUM_HARTS < VEC_W) ? NUM_HARTS : VEC_W;
   localparam logic [DEC_W-1:0] MTIME_LO = DEC_W'(MTIME_OFFSET);
   localparam logic [DEC_W-1:0] MTIME_HI = DEC_W'(MTIME_OFFSET + 4);

   // Architectural state
   logic [TIME_W-1:0] time_ff, time_in;
   logic [TIME_W-1:0] cmp_ff [NUM_HARTS];
   logic [TIME_W-1:0] cmp_in [NUM_HARTS];
   logic [NUM_HARTS-1:0] soft_ff, soft_in;

   // Input register stage
   logic              s1_valid_ff, s1_valid_in;
   op_type            s1_op_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [DATA_W-1:0] s1_wdata_ff;

   // State update stage: holds the read word of the item just applied
   logic              s2_valid_ff, s2_valid_in;
   logic [DATA_W-1:0] s2_rdata_ff, rdata_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_rdata_ff;
   logic [VEC_W-1:0]  rsp_tp_ff, rsp_sp_ff, tp_in, sp_in;

   // Handshake
   logic rsp_free, s2_move, s2_free, s1_move, s1_free, req_accept;

   // Decode
   logic [DEC_W-1:0]  addr_dec;
   logic              time_lo_hit, time_hi_hit;
   logic              cmp_hit, cmp_high, soft_hit;
   logic [HART_W-1:0] cmp_sel, soft_sel;

   // ---------------------------------------------------------------
   // Flow control: each stage loads when empty or when it drains.
   // The state only changes when stage two is empty or moves on, so
   // the pending vectors sampled into the result register always see
   // the state as the item in stage two left it.
   // ---------------------------------------------------------------
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s2_move    = s2_valid_ff && rsp_free;
   assign s2_free    = !s2_valid_ff || rsp_free;
   assign s1_move    = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;
   assign req_accept = req_tvalid && s1_free;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s2_free);
   assign s2_valid_in  = s1_move || (s2_valid_ff && !rsp_free);
   assign rsp_valid_in = s2_move || (rsp_valid_ff && !rsp_tready);

   // ---------------------------------------------------------------
   // Address decode. Time wins over compare registers, which win over
   // software bits; among harts the lowest wins (loops run downwards
   // so the lowest match is written last).
   // ---------------------------------------------------------------
   always_comb begin
      addr_dec    = {1'b0, s1_addr_ff};
      time_lo_hit = (addr_dec == MTIME_LO);
      time_hi_hit = (addr_dec == MTIME_HI);
      cmp_hit     = 1'b0;
      cmp_high    = 1'b0;
      cmp_sel     = '0;
      soft_hit    = 1'b0;
      soft_sel    = '0;
      for (int h = NUM_HARTS - 1; h >= 0; h--) begin
         if (addr_dec == DEC_W'(MTIMECMP_OFFSET + 8 * h)) begin
            cmp_hit  = 1'b1;
            cmp_high = 1'b0;
            cmp_sel  = HART_W'(h);
         end else if (addr_dec == DEC_W'(MTIMECMP_OFFSET + 8 * h + 4)) begin
            cmp_hit  = 1'b1;
            cmp_high = 1'b1;
            cmp_sel  = HART_W'(h);
         end
         if (addr_dec == DEC_W'(MSIP_OFFSET + 4 * h)) begin
            soft_hit = 1'b1;
            soft_sel = HART_W'(h);
         end
      end
   end

   // ---------------------------------------------------------------
   // Apply the item in stage one to the state and pick the read word
   // ---------------------------------------------------------------
   always_comb begin
      time_in  = time_ff;
      cmp_in   = cmp_ff;
      soft_in  = soft_ff;
      rdata_in = '0;
      if (s1_move) begin
         case (s1_op_ff)
            OP_TICK: begin
               time_in = time_ff + TIME_W'(1);
            end
            OP_READ: begin
               if (time_lo_hit) begin
                  rdata_in = time_ff[DATA_W-1:0];
               end else if (time_hi_hit) begin
                  rdata_in = time_ff[TIME_W-1:DATA_W];
               end else if (cmp_hit) begin
                  rdata_in = cmp_high ? cmp_ff[cmp_sel][TIME_W-1:DATA_W]
                                      : cmp_ff[cmp_sel][DATA_W-1:0];
               end else if (soft_hit) begin
                  rdata_in = DATA_W'(soft_ff[soft_sel]);
               end
            end
            OP_WRITE: begin
               if (time_lo_hit) begin
                  time_in[DATA_W-1:0] = s1_wdata_ff;
               end else if (time_hi_hit) begin
                  time_in[TIME_W-1:DATA_W] = s1_wdata_ff;
               end else if (cmp_hit) begin
                  if (cmp_high) begin
                     cmp_in[cmp_sel][TIME_W-1:DATA_W] = s1_wdata_ff;
                  end else begin
                     cmp_in[cmp_sel][DATA_W-1:0] = s1_wdata_ff;
                  end
               end else if (soft_hit) begin
                  soft_in[soft_sel] = s1_wdata_ff[0];
               end
            end
            default: begin
               // unused operation code: idle, nothing changes
            end
         endcase
      end
   end

   // Pending vectors from the current state; only the first four harts show
   always_comb begin
      tp_in = '0;
      sp_in = '0;
      for (int h = 0; h < VEC_HARTS; h++) begin
         tp_in[h] = (time_ff >= cmp_ff[h]);
         sp_in[h] = soft_ff[h];
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         soft_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int h = 0; h < NUM_HARTS; h++) begin
            cmp_ff[h] <= '1;
         end
      end else begin
         time_ff      <= time_in;
         soft_ff      <= soft_in;
         cmp_ff       <= cmp_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load whenever the stage is free
   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_op_ff    <= op_type'(req_tuser);
         s1_addr_ff  <= req_tdata[ADDR_W-1:0];
         s1_wdata_ff <= req_tdata[ADDR_W+DATA_W-1:ADDR_W];
      end
      if (s2_free) begin
         s2_rdata_ff <= rdata_in;
      end
      if (rsp_free) begin
         rsp_rdata_ff <= s2_rdata_ff;
         rsp_tp_ff    <= tp_in;
         rsp_sp_ff    <= sp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_sp_ff, rsp_tp_ff, rsp_rdata_ff};

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // State may only move while stage two is empty or draining
   a_state_order: assert property (@(posedge clock) disable iff (reset)
      (!s2_valid_ff || rsp_free) || !s1_move)
      else $error("state updated while stage two was stalled");

   // A tick applied advances time by exactly one
   a_tick: assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_op_ff == OP_TICK) |=> (time_ff == $past(time_ff) + TIME_W'(1)))
      else $error("tick did not advance time by one");

   // Time changes only through an applied item
   a_time_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_move |=> $stable(time_ff))
      else $error("time changed with no item applied");

   // A full, stalled pipeline takes no new item
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("item accepted into a full pipeline");

endmodule

@@ verif/core_local_interruptor_core_tb.sv @@
// Self-checking bench for core_local_interruptor_core: ticks, reads and writes over the
// register map, checked against a cycle-free model of time, compare and software bits.
// Depends on clint_pkg and the core under hdl/.
`timescale 1ns / 1ps

module core_local_interruptor_core_tb;

   import clint_pkg::*;

   localparam int NUM_HARTS       = 4;
   localparam int MSIP_OFFSET     = 0;
   localparam int MTIMECMP_OFFSET = 16384;
   localparam int MTIME_OFFSET    = 49144;

   // Code three is not in op_type; the core treats it as an idle item
   localparam logic [OP_W-1:0] OP_IDLE = 2'd3;

   localparam int RANDOM_ITEMS    = 600;
   localparam int HOLD_OFF_CYCLES = 40;    // long receiver stall, fills the pipeline
   localparam int DRAIN_CYCLES    = 8;     // margin after the three-stage pipeline has drained
   localparam int IDLE_LIMIT      = 2000;  // cycles without any handshake
   localparam int REPORT_LIMIT    = 10;

   // Result item as it sits in rsp_tdata, last field in the lowest bits
   typedef struct packed {
      logic [VEC_W-1:0]  software_pending;
      logic [VEC_W-1:0]  timer_pending;
      logic [DATA_W-1:0] read_data;
   } response_type;

   // Tracks time, compare values and software bits, and holds the responses
   // still owed by the core in arrival order.
   class interruptor_model;
      bit [TIME_W-1:0] mtime;
      bit [TIME_W-1:0] mtimecmp [NUM_HARTS];
      bit              msip [NUM_HARTS];
      response_type    owed_responses [$];
      int failures, checked, ticks, reads, writes, idles, timer_hits;

      function new();
         mtime = '0;
         for (int h = 0; h < NUM_HARTS; h++) begin
            mtimecmp[h] = '1;
            msip[h]     = 1'b0;
         end
      endfunction

      // Exact offset match only; time wins over compare, compare over software bits
      function bit [DATA_W-1:0] access_word(int unsigned offset, bit is_write,
                                            bit [DATA_W-1:0] wdata);
         int unsigned base;
         if (offset == MTIME_OFFSET || offset == MTIME_OFFSET + 4) begin
            if (is_write) begin
               if (offset != MTIME_OFFSET) mtime[63:32] = wdata;
               else mtime[31:0] = wdata;
               return '0;
            end
            return (offset != MTIME_OFFSET) ? mtime[63:32] : mtime[31:0];
         end
         for (int h = 0; h < NUM_HARTS; h++) begin
            base = MTIMECMP_OFFSET + 8 * h;
            if (offset == base || offset == base + 4) begin
               if (is_write) begin
                  if (offset != base) mtimecmp[h][63:32] = wdata;
                  else mtimecmp[h][31:0] = wdata;
                  return '0;
               end
               return (offset != base) ? mtimecmp[h][63:32] : mtimecmp[h][31:0];
            end
         end
         for (int h = 0; h < NUM_HARTS; h++) begin
            if (offset == MSIP_OFFSET + 4 * h) begin
               if (is_write) begin
                  msip[h] = wdata[0];
                  return '0;
               end
               return {31'd0, msip[h]};
            end
         end
         return '0;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                 logic [DATA_W-1:0] wdata);
         response_type owed;
         owed = '0;
         case (op)
            OP_TICK: begin
               mtime = mtime + TIME_W'(1);
               ticks++;
            end
            OP_READ: begin
               owed.read_data = access_word(addr, 1'b0, '0);
               reads++;
            end
            OP_WRITE: begin
               void'(access_word(addr, 1'b1, wdata));
               writes++;
            end
            default: idles++;
         endcase
         for (int h = 0; h < NUM_HARTS && h < VEC_W; h++) begin
            owed.timer_pending[h]    = (mtime >= mtimecmp[h]);
            owed.software_pending[h] = msip[h];
         end
         owed_responses.push_back(owed);
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] tdata);
         response_type got;
         response_type owed;
         got = tdata;
         checked++;
         if (got.timer_pending != '0) timer_hits++;
         if (owed_responses.size() == 0) begin
            if (failures < REPORT_LIMIT)
               $display("[%0t] unexpected response %h", $realtime, tdata);
            failures++;
            return;
         end
         owed = owed_responses.pop_front();
         if (got.read_data !== owed.read_data || got.timer_pending !== owed.timer_pending ||
             got.software_pending !== owed.software_pending) begin
            if (failures < REPORT_LIMIT)
               $display("[%0t] response %0d: read_data %h/%h timer %b/%b soft %b/%b (exp/got)",
                        $realtime, checked, owed.read_data, got.read_data,
                        owed.timer_pending, got.timer_pending,
                        owed.software_pending, got.software_pending);
            failures++;
         end
      endfunction

      function int outstanding();
         return owed_responses.size();
      endfunction

      // Anything still owed at the end is a failure of its own
      function void flush_leftovers();
         if (owed_responses.size() != 0) begin
            $display("%0d responses never arrived", owed_responses.size());
            failures += owed_responses.size();
            owed_responses.delete();
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [15:0] address, [47:16] write_data
   logic [OP_W-1:0]        req_tuser  = '0;   // [1:0] operation
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [31:0] read_data, [35:32] timer, [39:36] soft

   interruptor_model model = new();

   bit steady;             // both sides run without gaps while set
   bit hold_off_pending;   // ask the receiver for one long stall
   int idle_cycles;

   always #1 clock = ~clock;

   core_local_interruptor_core #(
      .NUM_HARTS      (NUM_HARTS),
      .MSIP_OFFSET    (MSIP_OFFSET),
      .MTIMECMP_OFFSET(MTIMECMP_OFFSET),
      .MTIME_OFFSET   (MTIME_OFFSET)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // Offer one item after a random gap and hold it until the core takes it.
   // Returns at the accepting edge, so a follow-on item with no gap keeps
   // valid high without a second assignment in the same step.
   task automatic send_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                            logic [DATA_W-1:0] wdata);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {wdata, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model.note_request(op, addr, wdata);
   endtask

   // Index 0..13 over the map: software bits, compare low/high per hart, time low/high
   function automatic logic [ADDR_W-1:0] mapped_offset(int unsigned idx);
      if (idx < NUM_HARTS) return ADDR_W'(MSIP_OFFSET + 4 * idx);
      if (idx < 3 * NUM_HARTS) return ADDR_W'(MTIMECMP_OFFSET + 4 * (idx - NUM_HARTS));
      return ADDR_W'(MTIME_OFFSET + 4 * (idx - 3 * NUM_HARTS));
   endfunction

   // Mostly mapped accesses and ticks, with small data so that time crosses
   // the compare values often; the rest is noise at random or unaligned offsets.
   task automatic draw_access(output logic [OP_W-1:0] op, output logic [ADDR_W-1:0] addr,
                              output logic [DATA_W-1:0] wdata);
      int unsigned pick;
      int unsigned target;
      pick  = $urandom_range(0, 99);
      addr  = ADDR_W'($urandom);
      case ($urandom_range(0, 3))
         0:       wdata = DATA_W'($urandom_range(0, 15));
         1:       wdata = '1;
         default: wdata = $urandom;
      endcase
      if (pick < 30) begin
         op = OP_TICK;
      end else if (pick < 34) begin
         op = OP_IDLE;
      end else begin
         op     = ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
         target = $urandom_range(0, 9);
         if (target < 7)
            addr = mapped_offset($urandom_range(0, 3 * NUM_HARTS + 1));
         else if (target == 7)
            addr = mapped_offset($urandom_range(0, 3 * NUM_HARTS + 1)) +
                   ADDR_W'($urandom_range(1, 3));
      end
   endtask

   // Take results after a random stall, or one long stall when asked for
   initial begin : receiver
      int stall;
      @(negedge reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 3);
         if (hold_off_pending) begin
            stall            = HOLD_OFF_CYCLES;
            hold_off_pending = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         model.check_response(rsp_tdata);
      end
   end

   // Drop the run when no item moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("** core_local_interruptor_core: FAILED **");
            $finish;
         end
      end
   end

   initial begin : sender
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values of time, compare registers and software bits
      send_item(OP_READ, ADDR_W'(MTIME_OFFSET), '0);
      send_item(OP_READ, ADDR_W'(MTIME_OFFSET + 4), '0);
      send_item(OP_READ, ADDR_W'(MTIMECMP_OFFSET), '0);
      send_item(OP_READ, ADDR_W'(MTIMECMP_OFFSET + 8 * (NUM_HARTS - 1) + 4), '0);
      send_item(OP_READ, ADDR_W'(MSIP_OFFSET), '0);
      // Only bit 0 of a software word is kept
      send_item(OP_WRITE, ADDR_W'(MSIP_OFFSET), 32'hFFFF_FFFF);
      send_item(OP_WRITE, ADDR_W'(MSIP_OFFSET + 4 * (NUM_HARTS - 1)), 32'hFFFF_FFFE);
      send_item(OP_READ, ADDR_W'(MSIP_OFFSET), '0);
      send_item(OP_READ, ADDR_W'(MSIP_OFFSET + 4 * (NUM_HARTS - 1)), '0);
      // Compare of zero makes hart 1 pend at once
      send_item(OP_WRITE, ADDR_W'(MTIMECMP_OFFSET + 8), '0);
      send_item(OP_WRITE, ADDR_W'(MTIMECMP_OFFSET + 12), '0);
      send_item(OP_READ, ADDR_W'(MTIMECMP_OFFSET + 12), '0);
      // Time just below all ones: one tick reaches the all-ones compares, the next wraps
      send_item(OP_WRITE, ADDR_W'(MTIME_OFFSET + 4), 32'hFFFF_FFFF);
      send_item(OP_WRITE, ADDR_W'(MTIME_OFFSET), 32'hFFFF_FFFE);
      send_item(OP_TICK, '0, '0);
      send_item(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(OP_READ, ADDR_W'(MTIME_OFFSET), '0);
      send_item(OP_READ, ADDR_W'(MTIME_OFFSET + 4), '0);
      // Unaligned, unmapped and just-past-the-harts offsets
      send_item(OP_READ, ADDR_W'(MTIMECMP_OFFSET + 2), '0);
      send_item(OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(OP_READ, 16'hFFFF, '0);
      send_item(OP_READ, ADDR_W'(MSIP_OFFSET + 4 * NUM_HARTS), '0);
      // Idle code aimed at the time register must change nothing
      send_item(OP_IDLE, ADDR_W'(MTIME_OFFSET), 32'hFFFF_FFFF);
      send_item(OP_READ, ADDR_W'(MTIME_OFFSET), '0);
      send_item(OP_WRITE, ADDR_W'(MSIP_OFFSET), '0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Every fourth stretch of 64 items runs without gaps on either side
         steady = ((n / 64) % 4) == 3;
         // Stall the receiver for a long stretch while items keep coming
         if (n == 200) hold_off_pending = 1'b1;
         // Hold the input until the core has returned everything owed
         if (n == 400) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (model.outstanding() != 0) @(posedge clock);
         end
         draw_access(op, addr, wdata);
         send_item(op, addr, wdata);
      end
      req_tvalid <= 1'b0;
      steady     = 1'b0;

      while (model.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      model.flush_leftovers();

      $display("covered %0d ticks, %0d reads, %0d writes, %0d idle codes",
               model.ticks, model.reads, model.writes, model.idles);
      $display("checked %0d responses, %0d with a timer interrupt pending, %0d mismatches",
               model.checked, model.timer_hits, model.failures);
      if (model.failures == 0) begin
         $display("** core_local_interruptor_core: PASSED **");
      end else begin
         $display("** core_local_interruptor_core: FAILED **");
      end
      $finish;
   end

endmodule
